@@ hdl/lvbr_pkg.sv @@
// Shared types, character codes and the symbol classifier for the longest
// valid bracket run block. No dependencies.
package lvbr_pkg;

    localparam logic [7:0] CHR_OPEN_PAREN   = 8'h28;
    localparam logic [7:0] CHR_CLOSE_PAREN  = 8'h29;
    localparam logic [7:0] CHR_OPEN_SQUARE  = 8'h5B;
    localparam logic [7:0] CHR_CLOSE_SQUARE = 8'h5D;
    localparam logic [7:0] CHR_OPEN_CURLY   = 8'h7B;
    localparam logic [7:0] CHR_CLOSE_CURLY  = 8'h7D;
    localparam logic [7:0] CHR_OPEN_ANGLE   = 8'h3C;
    localparam logic [7:0] CHR_CLOSE_ANGLE  = 8'h3E;

    localparam int          BEST_W   = 16;
    localparam logic [15:0] BEST_MAX = 16'hFFFF;
    localparam int          KIND_W   = 2;

    typedef enum logic [1:0] {
        CLS_OPEN,
        CLS_CLOSE,
        CLS_OTHER
    } sym_class_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_PAREN,
        KIND_SQUARE,
        KIND_CURLY,
        KIND_ANGLE
    } bracket_kind_t;

    typedef struct packed {
        sym_class_t    cls;
        bracket_kind_t kind;
    } sym_info_t;

    function automatic sym_info_t classify(input logic [7:0] sym);
        sym_info_t info;
        info.cls  = CLS_OTHER;
        info.kind = KIND_PAREN;
        unique case (sym)
            CHR_OPEN_PAREN:   begin info.cls = CLS_OPEN;  info.kind = KIND_PAREN;  end
            CHR_OPEN_SQUARE:  begin info.cls = CLS_OPEN;  info.kind = KIND_SQUARE; end
            CHR_OPEN_CURLY:   begin info.cls = CLS_OPEN;  info.kind = KIND_CURLY;  end
            CHR_OPEN_ANGLE:   begin info.cls = CLS_OPEN;  info.kind = KIND_ANGLE;  end
            CHR_CLOSE_PAREN:  begin info.cls = CLS_CLOSE; info.kind = KIND_PAREN;  end
            CHR_CLOSE_SQUARE: begin info.cls = CLS_CLOSE; info.kind = KIND_SQUARE; end
            CHR_CLOSE_CURLY:  begin info.cls = CLS_CLOSE; info.kind = KIND_CURLY;  end
            CHR_CLOSE_ANGLE:  begin info.cls = CLS_CLOSE; info.kind = KIND_ANGLE;  end
            default:          begin info.cls = CLS_OTHER; info.kind = KIND_PAREN;  end
        endcase
        return info;
    endfunction

endpackage

@@ hdl/lvbr_stack_ram.sv @@
// Simple dual-port stack memory with one write port and one registered
// read port. No dependencies.
module lvbr_stack_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 18
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

@@ hdl/longest_valid_bracket_run_core.sv @@
// Top level of the longest valid bracket run block: stack control, scoring
// and output register. Depends on lvbr_pkg and lvbr_stack_ram.
//
// One character enters per transfer on the input channel (symbol,
// start_req); each one yields exactly one result transfer (best_length,
// overflow) on the output channel. start_req clears the stack, position,
// best length and overflow flag before its own character is scored.
// The stack top lives in registers and the entry below it is prefetched
// from the stack memory every cycle, so the block takes one character per
// cycle; the registered memory read is covered by a forwarding register
// after a push. A result is registered and appears in the cycle after its
// input transfer and waits in the output register; a new character is
// taken in the same cycle the held result leaves, so a stalled receiver
// stops the input only while a result is held.
// After reset the stack holds the marker at position zero and the output
// is empty. No clearing pass is needed: entries are always written before
// their contents are used.
module longest_valid_bracket_run_core #(
    parameter int STACK_DEPTH = 1024,
    parameter int POS_BITS    = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  symbol,
    input  logic        start_req,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] best_length,
    output logic        overflow
);

    localparam int SP_W    = $clog2(STACK_DEPTH + 1);
    localparam int AW      = $clog2(STACK_DEPTH);
    localparam int KW      = lvbr_pkg::KIND_W;
    localparam int ENTRY_W = POS_BITS + KW;
    localparam int EXT_W   = (POS_BITS > 16) ? POS_BITS : 17;
    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
    localparam logic [SP_W-1:0] SP_FULL = SP_W'(STACK_DEPTH);

    logic [SP_W-1:0]      sp_reg, sp_next;
    logic [POS_BITS-1:0]  top_pos_reg, top_pos_next;
    logic [KW-1:0]        top_kind_reg, top_kind_next;
    logic [POS_BITS-1:0]  pos_reg, pos_next;
    logic [15:0]          best_reg, best_next;
    logic                 ovf_reg, ovf_next;
    logic                 fwd_valid_reg, fwd_valid_next;
    logic [ENTRY_W-1:0]   fwd_data_reg, fwd_data_next;
    logic                 out_valid_reg;
    logic [15:0]          out_best_reg;
    logic                 out_ovf_reg;

    logic                 accept;
    logic [SP_W-1:0]      sp_e;
    logic [POS_BITS-1:0]  top_pos_e;
    logic [POS_BITS-1:0]  pos_e;
    logic [15:0]          best_e;
    logic                 ovf_e;
    logic [POS_BITS-1:0]  pos_new;
    logic [ENTRY_W-1:0]   rd_data;
    logic [ENTRY_W-1:0]   below;
    logic [POS_BITS-1:0]  below_pos;
    logic [KW-1:0]        below_kind;
    logic [POS_BITS-1:0]  len;
    logic [EXT_W-1:0]     len_ext;
    logic [15:0]          len_sat;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        rd_addr;
    logic [SP_W-1:0]      sp_rd;
    lvbr_pkg::sym_info_t  info;

    assign accept   = in_valid && in_ready;
    assign in_ready = !out_valid_reg || out_ready;

    assign sp_e      = start_req ? SP_W'(1) : sp_reg;
    assign top_pos_e = start_req ? '0 : top_pos_reg;
    assign pos_e     = start_req ? '0 : pos_reg;
    assign best_e    = start_req ? '0 : best_reg;
    assign ovf_e     = start_req ? 1'b0 : ovf_reg;

    assign pos_new    = (pos_e == POS_MAX) ? pos_e : pos_e + POS_BITS'(1);
    assign below      = fwd_valid_reg ? fwd_data_reg : rd_data;
    assign below_pos  = below[ENTRY_W-1:KW];
    assign below_kind = below[KW-1:0];
    assign info       = lvbr_pkg::classify(symbol);

    assign len     = (pos_new > below_pos) ? (pos_new - below_pos) : '0;
    assign len_ext = EXT_W'(len);
    assign len_sat = (len_ext > EXT_W'(lvbr_pkg::BEST_MAX)) ? lvbr_pkg::BEST_MAX
                                                            : len_ext[15:0];

    always_comb
    begin
        sp_next        = sp_reg;
        top_pos_next   = top_pos_reg;
        top_kind_next  = top_kind_reg;
        pos_next       = pos_reg;
        best_next      = best_reg;
        ovf_next       = ovf_reg;
        fwd_valid_next = 1'b0;
        fwd_data_next  = fwd_data_reg;
        wr_en          = 1'b0;
        wr_addr        = AW'(sp_e - SP_W'(1));
        if (accept)
        begin
            pos_next  = pos_new;
            best_next = best_e;
            ovf_next  = ovf_e || (pos_e == POS_MAX);
            sp_next   = sp_e;
            top_pos_next = top_pos_e;
            unique case (info.cls)
                lvbr_pkg::CLS_OPEN:
                begin
                    if (sp_e < SP_FULL)
                    begin
                        wr_en          = 1'b1;
                        fwd_valid_next = 1'b1;
                        fwd_data_next  = {top_pos_e, top_kind_reg};
                        sp_next        = sp_e + SP_W'(1);
                        top_pos_next   = pos_new;
                        top_kind_next  = info.kind;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                lvbr_pkg::CLS_CLOSE:
                begin
                    if (sp_e >= SP_W'(2) && top_kind_reg == info.kind)
                    begin
                        sp_next       = sp_e - SP_W'(1);
                        top_pos_next  = below_pos;
                        top_kind_next = below_kind;
                        if (len_ext > EXT_W'(lvbr_pkg::BEST_MAX))
                        begin
                            ovf_next = 1'b1;
                        end
                        if (len_sat > best_e)
                        begin
                            best_next = len_sat;
                        end
                    end
                    else
                    begin
                        sp_next      = SP_W'(1);
                        top_pos_next = pos_new;
                    end
                end
                default:
                begin
                    sp_next      = SP_W'(1);
                    top_pos_next = pos_new;
                end
            endcase
        end
    end

    assign sp_rd   = sp_next - SP_W'(2);
    assign rd_addr = sp_rd[AW-1:0];

    lvbr_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({top_pos_e, top_kind_reg}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg        <= SP_W'(1);
            top_pos_reg   <= '0;
            top_kind_reg  <= '0;
            pos_reg       <= '0;
            best_reg      <= '0;
            ovf_reg       <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sp_reg        <= sp_next;
            top_pos_reg   <= top_pos_next;
            top_kind_reg  <= top_kind_next;
            pos_reg       <= pos_next;
            best_reg      <= best_next;
            ovf_reg       <= ovf_next;
            fwd_valid_reg <= fwd_valid_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_data_reg <= fwd_data_next;
        if (accept)
        begin
            out_best_reg <= best_next;
            out_ovf_reg  <= ovf_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign best_length = out_best_reg;
    assign overflow    = out_ovf_reg;

    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg != '0 && sp_reg <= SP_FULL)
        else $error("stack pointer out of range");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg && out_best_reg == best_reg && out_ovf_reg == ovf_reg)
        else $error("result does not match scoring state");

    a_best_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !start_req) |=> best_reg >= $past(best_reg))
        else $error("best length decreased within a string");

    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !start_req && ovf_reg) |=> ovf_reg)
        else $error("overflow flag dropped within a string");

    a_fwd_after_push: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid_reg |-> $past(accept) && sp_reg >= SP_W'(2))
        else $error("forwarding register set without a push");

endmodule

@@ tb/sv/tb_longest_valid_bracket_run_core.sv @@
// Self-checking testbench for longest_valid_bracket_run_core: drives strings of
// bracket and other characters under random and patterned flow control and
// checks every result. Depends on lvbr_pkg and the block's RTL.
module tb_longest_valid_bracket_run_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          STACK_DEPTH = 1024;
    localparam int          POS_BITS    = 16;
    localparam logic [15:0] POS_MAX     = 16'hFFFF;
    localparam int          CYCLE_LIMIT = 100000;

    typedef struct packed {
        logic [15:0] best;
        logic        ovf;
    } run_result_t;

    typedef enum {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_PATTERN
    } sink_mode_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  symbol;
    logic        start_req;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] best_length;
    logic        overflow;

    // Predictor state for the current string.
    logic [POS_BITS-1:0]     nest_pos [STACK_DEPTH];
    lvbr_pkg::bracket_kind_t nest_kind [STACK_DEPTH];
    int                      nest_depth;
    logic [POS_BITS-1:0]     char_pos;
    logic [15:0]             best_run;
    logic                    sat_flag;

    run_result_t expected_runs[$];
    int          error_count;
    int          cycle_count;
    int          burst_left;
    int          gap_max;
    sink_mode_t  sink_mode;
    int          hold_request;
    int          hold_left;
    logic [10:0] stall_pattern;

    longest_valid_bracket_run_core #(
        .STACK_DEPTH(STACK_DEPTH),
        .POS_BITS   (POS_BITS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .symbol     (symbol),
        .start_req  (start_req),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .best_length(best_length),
        .overflow   (overflow)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] open_char(input lvbr_pkg::bracket_kind_t k);
        case (k)
            lvbr_pkg::KIND_PAREN:  return lvbr_pkg::CHR_OPEN_PAREN;
            lvbr_pkg::KIND_SQUARE: return lvbr_pkg::CHR_OPEN_SQUARE;
            lvbr_pkg::KIND_CURLY:  return lvbr_pkg::CHR_OPEN_CURLY;
            default:               return lvbr_pkg::CHR_OPEN_ANGLE;
        endcase
    endfunction

    function automatic logic [7:0] close_char(input lvbr_pkg::bracket_kind_t k);
        case (k)
            lvbr_pkg::KIND_PAREN:  return lvbr_pkg::CHR_CLOSE_PAREN;
            lvbr_pkg::KIND_SQUARE: return lvbr_pkg::CHR_CLOSE_SQUARE;
            lvbr_pkg::KIND_CURLY:  return lvbr_pkg::CHR_CLOSE_CURLY;
            default:               return lvbr_pkg::CHR_CLOSE_ANGLE;
        endcase
    endfunction

    function automatic void decode_symbol(input logic [7:0] s,
                                          output lvbr_pkg::sym_class_t cls,
                                          output lvbr_pkg::bracket_kind_t kind);
        cls  = lvbr_pkg::CLS_OTHER;
        kind = lvbr_pkg::KIND_PAREN;
        for (int k = 0; k < 4; k++)
        begin
            if (s == open_char(lvbr_pkg::bracket_kind_t'(k)))
            begin
                cls  = lvbr_pkg::CLS_OPEN;
                kind = lvbr_pkg::bracket_kind_t'(k);
            end
            else if (s == close_char(lvbr_pkg::bracket_kind_t'(k)))
            begin
                cls  = lvbr_pkg::CLS_CLOSE;
                kind = lvbr_pkg::bracket_kind_t'(k);
            end
        end
    endfunction

    function automatic void place_marker(input logic [POS_BITS-1:0] p);
        nest_pos[0]  = p;
        nest_kind[0] = lvbr_pkg::KIND_PAREN;
        nest_depth   = 1;
    endfunction

    function automatic void restart_string();
        place_marker('0);
        char_pos = '0;
        best_run = '0;
        sat_flag = 1'b0;
    endfunction

    function automatic run_result_t score_symbol(input logic [7:0] s, input logic st);
        lvbr_pkg::sym_class_t    cls;
        lvbr_pkg::bracket_kind_t kind;
        int unsigned             span;
        run_result_t             r;
        if (st)
            restart_string();
        if (char_pos == POS_MAX)
            sat_flag = 1'b1;
        else
            char_pos = char_pos + 1'b1;
        decode_symbol(s, cls, kind);
        if (cls == lvbr_pkg::CLS_OPEN)
        begin
            if (nest_depth < STACK_DEPTH)
            begin
                nest_pos[nest_depth]  = char_pos;
                nest_kind[nest_depth] = kind;
                nest_depth++;
            end
            else
                sat_flag = 1'b1;
        end
        else if (cls == lvbr_pkg::CLS_CLOSE && nest_depth >= 2
                 && nest_kind[nest_depth-1] == kind)
        begin
            nest_depth--;
            span = (char_pos > nest_pos[nest_depth-1]) ?
                   int'(char_pos) - int'(nest_pos[nest_depth-1]) : 0;
            if (span > lvbr_pkg::BEST_MAX)
            begin
                span     = lvbr_pkg::BEST_MAX;
                sat_flag = 1'b1;
            end
            if (span > best_run)
                best_run = span[15:0];
        end
        else
            place_marker(char_pos);
        r.best = best_run;
        r.ovf  = sat_flag;
        return r;
    endfunction

    task automatic send_symbol(input logic [7:0] s, input logic st);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap        = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        symbol    <= s;
        start_req <= st;
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        expected_runs.insert(expected_runs.size(), score_symbol(s, st));
        @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        burst_left = 0;
        while (expected_runs.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            case (sink_mode)
                SINK_OPEN:   out_ready <= 1'b1;
                SINK_RANDOM: out_ready <= ($urandom_range(0, 2) != 0);
                default:
                begin
                    out_ready     <= stall_pattern[0];
                    stall_pattern <= {stall_pattern[0], stall_pattern[10:1]};
                end
            endcase
        end
    end

    always @(negedge clk)
    begin
        run_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_runs.size() == 0)
            begin
                $error("result transfer with nothing expected: best_length %0d", best_length);
                error_count++;
            end
            else
            begin
                want = expected_runs.pop_front();
                if (best_length !== want.best)
                begin
                    $error("best_length: expected %0d, got %0d", want.best, best_length);
                    error_count++;
                end
                if (overflow !== want.ovf)
                begin
                    $error("overflow: expected %0b, got %0b", want.ovf, overflow);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_longest_valid_bracket_run_core: done, errors");
            $finish;
        end
    end

    task automatic test_directed();
        gap_max   = 0;
        sink_mode = SINK_PATTERN;
        send_symbol(lvbr_pkg::CHR_OPEN_PAREN, 1'b1);
        send_symbol(lvbr_pkg::CHR_CLOSE_PAREN, 1'b0);
        send_symbol(lvbr_pkg::CHR_OPEN_SQUARE, 1'b0);
        send_symbol(lvbr_pkg::CHR_OPEN_CURLY, 1'b0);
        send_symbol(lvbr_pkg::CHR_CLOSE_CURLY, 1'b0);
        send_symbol(lvbr_pkg::CHR_CLOSE_SQUARE, 1'b0);
        send_symbol(lvbr_pkg::CHR_OPEN_ANGLE, 1'b0);
        send_symbol(lvbr_pkg::CHR_CLOSE_ANGLE, 1'b0);
        // A closer with only the marker below it fails and moves the marker.
        send_symbol(lvbr_pkg::CHR_CLOSE_PAREN, 1'b0);
        send_symbol(8'h00, 1'b0);
        send_symbol(8'hFF, 1'b0);
        send_symbol(lvbr_pkg::CHR_OPEN_PAREN, 1'b0);
        send_symbol(lvbr_pkg::CHR_CLOSE_SQUARE, 1'b0);
        send_symbol(lvbr_pkg::CHR_OPEN_CURLY, 1'b0);
        send_symbol(lvbr_pkg::CHR_OPEN_ANGLE, 1'b0);
        send_symbol(lvbr_pkg::CHR_CLOSE_ANGLE, 1'b0);
        send_symbol(lvbr_pkg::CHR_CLOSE_CURLY, 1'b0);
        send_symbol(lvbr_pkg::CHR_CLOSE_ANGLE, 1'b1);
        send_symbol(lvbr_pkg::CHR_OPEN_ANGLE, 1'b0);
        send_symbol(lvbr_pkg::CHR_CLOSE_ANGLE, 1'b0);
        send_symbol(lvbr_pkg::CHR_OPEN_SQUARE, 1'b1);
        send_symbol(lvbr_pkg::CHR_CLOSE_CURLY, 1'b0);
        wait_drained();
    endtask

    task automatic send_random_strings(input int n_items);
        lvbr_pkg::bracket_kind_t open_kinds[$];
        lvbr_pkg::bracket_kind_t k;
        logic [7:0]              sym;
        logic                    st;
        int                      sent;
        int                      len;
        int                      r;
        sent = 0;
        while (sent < n_items)
        begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 300) : $urandom_range(1, 30);
            open_kinds.delete();
            for (int i = 0; i < len && sent < n_items; i++)
            begin
                st = ((i == 0) && ($urandom_range(0, 9) != 0)) || ($urandom_range(0, 99) == 0);
                if (st)
                    open_kinds.delete();
                r = $urandom_range(0, 99);
                if (r < 45)
                begin
                    k = lvbr_pkg::bracket_kind_t'($urandom_range(0, 3));
                    open_kinds.insert(open_kinds.size(), k);
                    sym = open_char(k);
                end
                else if (r < 85 && open_kinds.size() > 0)
                begin
                    sym = close_char(open_kinds[$]);
                    open_kinds.delete(open_kinds.size() - 1);
                end
                else if (r < 93)
                begin
                    sym = close_char(lvbr_pkg::bracket_kind_t'($urandom_range(0, 3)));
                    open_kinds.delete();
                end
                else
                begin
                    sym = 8'($urandom_range(0, 255));
                    open_kinds.delete();
                end
                send_symbol(sym, st);
                sent++;
            end
        end
    endtask

    task automatic test_random_strings();
        gap_max   = 4;
        sink_mode = SINK_RANDOM;
        send_random_strings(230);
        gap_max   = 0;
        sink_mode = SINK_OPEN;
        send_random_strings(230);
        gap_max   = 6;
        sink_mode = SINK_PATTERN;
        send_random_strings(230);
        wait_drained();
    endtask

    task automatic test_backpressure();
        gap_max      = 0;
        sink_mode    = SINK_OPEN;
        hold_request = 400;
        send_random_strings(40);
        wait_drained();
    endtask

    task automatic test_stack_full();
        lvbr_pkg::bracket_kind_t pushed[$];
        lvbr_pkg::bracket_kind_t k;
        gap_max   = 2;
        sink_mode = SINK_RANDOM;
        for (int i = 0; i < STACK_DEPTH + 6; i++)
        begin
            k = lvbr_pkg::bracket_kind_t'($urandom_range(0, 3));
            pushed.insert(pushed.size(), k);
            send_symbol(open_char(k), i == 0);
        end
        // Only the first STACK_DEPTH - 1 openers were kept; close the newest of them.
        for (int j = 0; j < 8; j++)
            send_symbol(close_char(pushed[STACK_DEPTH - 2 - j]), 1'b0);
        send_symbol(8'h41, 1'b0);
        send_symbol(lvbr_pkg::CHR_OPEN_PAREN, 1'b0);
        send_symbol(lvbr_pkg::CHR_CLOSE_PAREN, 1'b0);
        wait_drained();
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        symbol        <= 8'h00;
        start_req     <= 1'b0;
        out_ready     <= 1'b0;
        stall_pattern <= 11'b10110111011;
        error_count  = 0;
        cycle_count  = 0;
        burst_left   = 0;
        gap_max      = 0;
        sink_mode    = SINK_OPEN;
        hold_request = 0;
        hold_left    = 0;
        restart_string();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_strings();
        test_backpressure();
        test_stack_full();

        repeat (8) @(posedge clk);
        if (error_count == 0 && expected_runs.size() == 0)
            $display("tb_longest_valid_bracket_run_core: done, clean");
        else
            $display("tb_longest_valid_bracket_run_core: done, errors");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/lvbr_pkg.sv
hdl/lvbr_stack_ram.sv
hdl/longest_valid_bracket_run_core.sv
tb/sv/tb_longest_valid_bracket_run_core.sv
